// File: rtl/grt_pkg.sv
// Shared codes and helpers for the occupancy grid line tracer.
package grt_pkg;

  typedef enum logic [1:0] {
    OP_TRACE = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  localparam logic [1:0] CELL_OCCUPIED = 2'd0;
  localparam logic [1:0] CELL_UNKNOWN  = 2'd1;
  localparam logic [1:0] CELL_FREE     = 2'd2;

  localparam logic [6:0] PUB_OCCUPIED = 7'd97;
  localparam logic [6:0] PUB_UNKNOWN  = 7'd50;
  localparam logic [6:0] PUB_FREE     = 7'd3;

  localparam int unsigned CfgRegs   = 2;
  localparam int unsigned CfgDataW  = 9;
  localparam logic [CfgDataW-1:0] GRID_SIZE_RESET = 9'd256;
  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  // Map a stored cell code to its published value.
  function automatic logic [6:0] cell_pub(input logic [1:0] code);
    logic [6:0] v;
    unique case (code)
      CELL_OCCUPIED: v = PUB_OCCUPIED;
      CELL_FREE:     v = PUB_FREE;
      default:       v = PUB_UNKNOWN;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/grid_ray_tracer.sv
// Occupancy grid with Bresenham line tracing, cell reads and grid clear.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+-------------------------------------------
//  command   | start, busy           | op, start_x, start_y, end_x, end_y,
//            |                       | cell_state, read_x, read_y
//  result    | done (one cycle)      | cell_value, cells_written, read_outside
//  config    | cfg_we                | cfg_index, cfg_data
//
// A trace visits one cell per cycle, from the start point to the end point; result in the next cycle.
// A read captures the cell in rd_data, passes through the S_READ state, then shows the result.
// A clear writes one cell per cycle over the whole cell store, then the result.
// Reset runs the same clearing pass with busy high.
// Results are shown for one cycle only; the receiver cannot stall them.
module grid_ray_tracer
  import grt_pkg::*;
#(
  parameter int MAX_COLUMNS = 256,
  parameter int MAX_ROWS    = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          op,
  input  logic signed [15:0]  start_x,
  input  logic signed [15:0]  start_y,
  input  logic signed [15:0]  end_x,
  input  logic signed [15:0]  end_y,
  input  logic [1:0]          cell_state,
  input  logic [7:0]          read_x,
  input  logic [7:0]          read_y,
  output logic                done,
  output logic [6:0]          cell_value,
  output logic [8:0]          cells_written,
  output logic                read_outside,
  input  logic                cfg_we,
  input  logic [$clog2(CfgRegs)-1:0] cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  localparam int Depth = MAX_COLUMNS * MAX_ROWS;
  localparam int AW    = $clog2(Depth);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CLEAR = 4'b0010,
    S_TRACE = 4'b0100,
    S_READ  = 4'b1000
  } state_t;

  state_t state;

  logic [CfgDataW-1:0] grid_width;
  logic [CfgDataW-1:0] grid_height;

  // Cell store
  logic [1:0]    cells [Depth];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [1:0]    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [1:0]    rd_data;

  // Walk state
  logic signed [15:0] tx, ty, txe, tye;
  logic [16:0]        dx, dy;
  logic               x_neg, y_neg;
  logic signed [18:0] err;
  logic [8:0]         cnt;
  logic [1:0]         code;
  logic [AW-1:0]      clr_addr;
  logic               clr_report;
  logic               rd_outside;

  logic               accept;
  logic signed [16:0] sxe, sye, exe, eye;
  logic [16:0]        dx_init, dy_init;
  logic signed [18:0] err_init;
  logic               rd_out_now;

  logic [15:0]        tx_u, ty_u;
  logic               in_grid;
  logic               at_end;
  logic [AW-1:0]      trace_addr;
  logic signed [19:0] e2, dx_w, dy_w, err_w;
  logic               step_x, step_y;
  logic [8:0]         cnt_inc;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // Line setup from the command ports
  always_comb begin
    sxe = 17'(start_x);
    sye = 17'(start_y);
    exe = 17'(end_x);
    eye = 17'(end_y);
    dx_init  = (exe > sxe) ? 17'(exe - sxe) : 17'(sxe - exe);
    dy_init  = (eye > sye) ? 17'(eye - sye) : 17'(sye - eye);
    err_init = $signed({2'b00, dx_init}) - $signed({2'b00, dy_init});
    rd_out_now = ({1'b0, read_x} >= grid_width) || ({1'b0, read_y} >= grid_height) ||
                 (32'(read_x) >= 32'(MAX_COLUMNS)) || (32'(read_y) >= 32'(MAX_ROWS));
  end

  // One Bresenham step
  always_comb begin
    tx_u = tx;
    ty_u = ty;
    in_grid = !tx[15] && !ty[15] &&
              (tx_u < {7'd0, grid_width}) && (ty_u < {7'd0, grid_height}) &&
              (32'(tx_u) < 32'(MAX_COLUMNS)) && (32'(ty_u) < 32'(MAX_ROWS));
    at_end     = (tx == txe) && (ty == tye);
    trace_addr = AW'(ty_u) * AW'(MAX_COLUMNS) + AW'(tx_u);
    err_w  = 20'(err);
    e2     = err_w <<< 1;
    dx_w   = 20'(dx);
    dy_w   = 20'(dy);
    step_x = e2 > -dy_w;
    step_y = e2 < dx_w;
    cnt_inc = (in_grid && cnt != '1) ? cnt + 9'd1 : cnt;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = CELL_UNKNOWN;
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (state == S_TRACE && in_grid) begin
      mem_we    = 1'b1;
      mem_waddr = trace_addr;
      mem_wdata = code;
    end
    mem_re    = accept && (op == OP_READ);
    mem_raddr = AW'(read_y) * AW'(MAX_COLUMNS) + AW'(read_x);
  end

  always_ff @(posedge clk) begin
    if (mem_we) cells[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data <= cells[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= GRID_SIZE_RESET;
      grid_height <= GRID_SIZE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:  grid_width  <= cfg_data;
        REG_GRID_HEIGHT: grid_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Payload registers of the walk
  always_ff @(posedge clk) begin
    if (accept) begin
      tx     <= start_x;
      ty     <= start_y;
      txe    <= end_x;
      tye    <= end_y;
      dx     <= dx_init;
      dy     <= dy_init;
      x_neg  <= !(start_x < end_x);
      y_neg  <= !(start_y < end_y);
      err    <= err_init;
      cnt    <= '0;
      code   <= cell_state;
      rd_outside <= rd_out_now;
    end else if (state == S_TRACE) begin
      cnt <= cnt_inc;
      if (step_x) tx <= x_neg ? tx - 16'sd1 : tx + 16'sd1;
      if (step_y) ty <= y_neg ? ty - 16'sd1 : ty + 16'sd1;
      err <= 19'(err_w - (step_x ? dy_w : 20'sd0) + (step_y ? dx_w : 20'sd0));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      clr_report    <= 1'b0;
      done          <= 1'b0;
      cell_value    <= '0;
      cells_written <= '0;
      read_outside  <= 1'b0;
    end else begin
      done          <= 1'b0;
      cell_value    <= '0;
      cells_written <= '0;
      read_outside  <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (op)
              OP_TRACE: begin
                // an invalid state code writes nothing
                if (cell_state <= CELL_FREE) state <= S_TRACE;
                else done <= 1'b1;
              end
              OP_READ: state <= S_READ;
              OP_CLEAR: begin
                state      <= S_CLEAR;
                clr_addr   <= '0;
                clr_report <= 1'b1;
              end
              default: done <= 1'b1;
            endcase
          end
        end
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(Depth - 1)) begin
            state      <= S_IDLE;
            done       <= clr_report;
            clr_report <= 1'b0;
          end
        end
        S_TRACE: begin
          if (at_end) begin
            state         <= S_IDLE;
            done          <= 1'b1;
            cells_written <= cnt_inc;
          end
        end
        S_READ: begin
          state        <= S_IDLE;
          done         <= 1'b1;
          read_outside <= rd_outside;
          cell_value   <= rd_outside ? 7'd0 : cell_pub(rd_data);
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_sweep_after_reset: assert property (@(posedge clk) $past(rst) |-> busy)
    else $error("block not busy after reset");

  a_no_result_in_sweep: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !done)
    else $error("result during clearing pass");

  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    (done && read_outside) |-> (cell_value == '0 && cells_written == '0))
    else $error("outside read carries data");

  a_count_from_trace: assert property (@(posedge clk) disable iff (rst)
    (done && cells_written != '0) |-> $past(state == S_TRACE))
    else $error("cell count not from a trace");

endmodule

// File: bench/grid_occupancy_checker.sv
// Checker for the occupancy grid line tracer: predicts every result and compares.
`timescale 1ns / 1ps

module grid_occupancy_checker
  import grt_pkg::*;
#(
  parameter int MAX_COLUMNS = 256,
  parameter int MAX_ROWS    = 256
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       busy,
  input  logic [1:0]                 op,
  input  logic signed [15:0]         start_x,
  input  logic signed [15:0]         start_y,
  input  logic signed [15:0]         end_x,
  input  logic signed [15:0]         end_y,
  input  logic [1:0]                 cell_state,
  input  logic [7:0]                 read_x,
  input  logic [7:0]                 read_y,
  input  logic                       done,
  input  logic [6:0]                 cell_value,
  input  logic [8:0]                 cells_written,
  input  logic                       read_outside,
  input  logic                       cfg_we,
  input  logic [$clog2(CfgRegs)-1:0] cfg_index,
  input  logic [CfgDataW-1:0]        cfg_data,
  output int                         mismatches,
  output int                         outstanding,
  output int                         compared
);

  localparam int unsigned COUNT_CAP = 511;

  typedef struct packed {
    logic [6:0] value;
    logic [8:0] written;
    logic       outside;
  } grid_outcome_t;

  logic [1:0]          grid_cells [MAX_COLUMNS*MAX_ROWS];
  logic [CfgDataW-1:0] cols_reg;
  logic [CfgDataW-1:0] rows_reg;
  grid_outcome_t       outcomes_due [$];

  function automatic int cols_in_use();
    return (cols_reg > MAX_COLUMNS) ? MAX_COLUMNS : int'(cols_reg);
  endfunction

  function automatic int rows_in_use();
    return (rows_reg > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
  endfunction

  function automatic void wipe_grid();
    foreach (grid_cells[i]) grid_cells[i] = CELL_UNKNOWN;
  endfunction

  // Walk the line, mark in-grid cells and return the saturated count.
  function automatic logic [8:0] mark_line(int x, int y, int xe, int ye, logic [1:0] code);
    int w, h, dx, dy, sx, sy, err, e2;
    int unsigned count;
    w = cols_in_use();
    h = rows_in_use();
    dx = (xe > x) ? xe - x : x - xe;
    dy = (ye > y) ? ye - y : y - ye;
    sx = (x < xe) ? 1 : -1;
    sy = (y < ye) ? 1 : -1;
    err = dx - dy;
    count = 0;
    forever begin
      if (x >= 0 && y >= 0 && x < w && y < h) begin
        grid_cells[y * MAX_COLUMNS + x] = code;
        if (count < COUNT_CAP) count++;
      end
      if (x == xe && y == ye) break;
      e2 = 2 * err;
      if (e2 > -dy) begin
        err -= dy;
        x += sx;
      end
      if (e2 < dx) begin
        err += dx;
        y += sy;
      end
    end
    return count[8:0];
  endfunction

  function automatic grid_outcome_t command_outcome();
    grid_outcome_t res;
    res = '0;
    case (op)
      OP_TRACE: begin
        if (cell_state <= CELL_FREE)
          res.written = mark_line(int'(start_x), int'(start_y), int'(end_x), int'(end_y),
                                  cell_state);
      end
      OP_READ: begin
        if (int'(read_x) >= cols_in_use() || int'(read_y) >= rows_in_use()) begin
          res.outside = 1'b1;
        end else begin
          case (grid_cells[int'(read_y) * MAX_COLUMNS + int'(read_x)])
            CELL_OCCUPIED: res.value = PUB_OCCUPIED;
            CELL_FREE:     res.value = PUB_FREE;
            default:       res.value = PUB_UNKNOWN;
          endcase
        end
      end
      OP_CLEAR: wipe_grid();
      default: ;
    endcase
    return res;
  endfunction

  task automatic report(string what, int unsigned want, int unsigned got);
    mismatches++;
    $display("%0d ns: %s: expected %0d, got %0d", $time, what, want, got);
  endtask

  always @(posedge clk) begin
    grid_outcome_t want;
    if (rst) begin
      wipe_grid();
      cols_reg = GRID_SIZE_RESET;
      rows_reg = GRID_SIZE_RESET;
      outcomes_due.delete();
    end else begin
      if (done) begin
        if (outcomes_due.size() == 0) begin
          report("result with no transaction pending", 0, 1);
        end else begin
          want = outcomes_due.pop_front();
          compared++;
          if (cell_value !== want.value) report("cell_value", want.value, cell_value);
          if (cells_written !== want.written)
            report("cells_written", want.written, cells_written);
          if (read_outside !== want.outside)
            report("read_outside", want.outside, read_outside);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_GRID_WIDTH:  cols_reg = cfg_data;
          REG_GRID_HEIGHT: rows_reg = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) outcomes_due.insert(outcomes_due.size(), command_outcome());
    end
    outstanding = outcomes_due.size();
  end

endmodule

// File: bench/tb_grid_ray_tracer.sv
// Testbench top for the occupancy grid line tracer: stimulus, reset and verdict.
`timescale 1ns / 1ps

module tb_grid_ray_tracer;
  import grt_pkg::*;

  localparam logic [1:0] OP_SPARE  = 2'd3;
  localparam logic [1:0] CELL_BAD  = 2'd3;
  localparam int         PHASES    = 10;
  localparam int         PER_PHASE = 140;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] op = OP_TRACE;
  logic signed [15:0] start_x = '0;
  logic signed [15:0] start_y = '0;
  logic signed [15:0] end_x = '0;
  logic signed [15:0] end_y = '0;
  logic [1:0] cell_state = CELL_OCCUPIED;
  logic [7:0] read_x = '0;
  logic [7:0] read_y = '0;
  logic done;
  logic [6:0] cell_value;
  logic [8:0] cells_written;
  logic read_outside;
  logic cfg_we = 1'b0;
  logic [$clog2(CfgRegs)-1:0] cfg_index = REG_GRID_WIDTH;
  logic [CfgDataW-1:0] cfg_data = '0;

  int mismatches, outstanding, compared;
  int cur_cols = 256;
  int cur_rows = 256;
  int last_x = 0;
  int last_y = 0;
  int burst_left = 0;
  int n_trace = 0, n_read = 0, n_clear = 0, n_spare = 0, n_sizes = 1;

  grid_ray_tracer dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
    .cell_state(cell_state), .read_x(read_x), .read_y(read_y),
    .done(done), .cell_value(cell_value), .cells_written(cells_written),
    .read_outside(read_outside),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  grid_occupancy_checker chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
    .cell_state(cell_state), .read_x(read_x), .read_y(read_y),
    .done(done), .cell_value(cell_value), .cells_written(cells_written),
    .read_outside(read_outside),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .outstanding(outstanding), .compared(compared)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #100_000_000;
    $display("grid_ray_tracer: mismatch");
    $finish;
  end

  // Drop start and hold until every result is back and the block is free.
  task automatic drain();
    start = 1'b0;
    while (outstanding != 0 || busy) @(negedge clk);
  endtask

  task automatic write_reg(logic [$clog2(CfgRegs)-1:0] idx, logic [CfgDataW-1:0] data);
    drain();
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_grid(int cols, int rows);
    write_reg(REG_GRID_WIDTH, cols[CfgDataW-1:0]);
    write_reg(REG_GRID_HEIGHT, rows[CfgDataW-1:0]);
    cur_cols = cols;
    cur_rows = rows;
    n_sizes++;
  endtask

  // Present one transaction after a gap and hold it until accepted.
  task automatic issue(logic [1:0] cmd, int sx, int sy, int ex, int ey,
                       logic [1:0] cs, int rx, int ry, int gap);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    op = cmd;
    start_x = sx[15:0];
    start_y = sy[15:0];
    end_x = ex[15:0];
    end_y = ey[15:0];
    cell_state = cs;
    read_x = rx[7:0];
    read_y = ry[7:0];
    start = 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
    case (cmd)
      OP_TRACE: n_trace++;
      OP_READ:  n_read++;
      OP_CLEAR: n_clear++;
      default:  n_spare++;
    endcase
  endtask

  task automatic random_command();
    int kind, shape, used_c, used_r, gap;
    int sx, sy, ex, ey, rx, ry;
    logic [1:0] cmd, cs;
    used_c = (cur_cols > 256) ? 256 : cur_cols;
    used_r = (cur_rows > 256) ? 256 : cur_rows;
    // unrelated fields carry noise
    sx = int'($signed($urandom_range(0, 65535) - 32768));
    sy = int'($signed($urandom_range(0, 65535) - 32768));
    ex = int'($signed($urandom_range(0, 65535) - 32768));
    ey = int'($signed($urandom_range(0, 65535) - 32768));
    rx = $urandom_range(0, 255);
    ry = $urandom_range(0, 255);
    cs = 2'($urandom_range(0, 3));
    kind = $urandom_range(0, 999);
    if (kind < 3) begin
      cmd = OP_CLEAR;
    end else if (kind < 40) begin
      cmd = OP_SPARE;
    end else if (kind < 400) begin
      cmd = OP_READ;
      shape = $urandom_range(0, 2);
      if (shape == 1 && used_c > 0 && used_r > 0) begin
        rx = $urandom_range(0, used_c - 1);
        ry = $urandom_range(0, used_r - 1);
      end else if (shape == 2 && last_x >= 0 && last_x < 256 && last_y >= 0 && last_y < 256) begin
        rx = last_x;
        ry = last_y;
      end
    end else begin
      cmd = OP_TRACE;
      cs = ($urandom_range(0, 19) == 0) ? CELL_BAD : 2'($urandom_range(0, 2));
      if ($urandom_range(0, 3) == 0) begin
        // short line anywhere in the coordinate space
        ex = sx + int'($urandom_range(0, 40)) - 20;
        ey = sy + int'($urandom_range(0, 40)) - 20;
        ex = (ex > 32767) ? 32767 : (ex < -32768) ? -32768 : ex;
        ey = (ey > 32767) ? 32767 : (ey < -32768) ? -32768 : ey;
      end else begin
        sx = int'($urandom_range(0, used_c + 16)) - 8;
        sy = int'($urandom_range(0, used_r + 16)) - 8;
        ex = int'($urandom_range(0, used_c + 16)) - 8;
        ey = int'($urandom_range(0, used_r + 16)) - 8;
      end
      last_x = ($urandom_range(0, 1) == 0) ? sx : ex;
      last_y = (last_x == sx) ? sy : ey;
    end
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else begin
      gap = $urandom_range(0, 7);
      if ($urandom_range(0, 29) == 0) burst_left = $urandom_range(15, 40);
    end
    if ($urandom_range(0, 59) == 0) drain();
    issue(cmd, sx, sy, ex, ey, cs, rx, ry, gap);
  endtask

  initial begin
    int cols, rows;
    repeat (10) @(negedge clk);
    rst = 1'b0;
    drain();

    // directed part on the full grid left by reset
    issue(OP_READ, 0, 0, 0, 0, CELL_OCCUPIED, 0, 0, 0);
    issue(OP_TRACE, 0, 0, 255, 0, CELL_OCCUPIED, 0, 0, 0);
    issue(OP_READ, 0, 0, 0, 0, CELL_OCCUPIED, 255, 0, 3);
    issue(OP_TRACE, -32768, -32768, 32767, 32767, CELL_FREE, 255, 255, 0);
    issue(OP_READ, 0, 0, 0, 0, CELL_FREE, 255, 255, 0);
    issue(OP_READ, 0, 0, 0, 0, CELL_FREE, 128, 128, 1);
    issue(OP_TRACE, 32767, -32768, -32768, 32767, CELL_OCCUPIED, 0, 0, 0);
    issue(OP_TRACE, 255, 0, 0, 255, CELL_UNKNOWN, 0, 0, 2);
    issue(OP_READ, 0, 0, 0, 0, CELL_OCCUPIED, 0, 255, 0);
    issue(OP_TRACE, 5, 5, 5, 5, CELL_FREE, 0, 0, 0);
    issue(OP_TRACE, 3, -10, 10, 300, CELL_FREE, 0, 0, 0);
    issue(OP_TRACE, 300, 7, -20, 2, CELL_OCCUPIED, 0, 0, 5);
    issue(OP_TRACE, 0, 1, 10, 1, CELL_BAD, 0, 0, 0);
    issue(OP_READ, 0, 0, 0, 0, CELL_OCCUPIED, 5, 1, 0);
    issue(OP_READ, 0, 0, 0, 0, CELL_OCCUPIED, 5, 5, 0);
    issue(OP_SPARE, -1, 32767, -32768, 1, CELL_BAD, 255, 255, 0);
    issue(OP_TRACE, 32767, 32767, 32767, 32767, CELL_OCCUPIED, 0, 0, 0);
    issue(OP_TRACE, -32768, 0, -32768, 0, CELL_OCCUPIED, 0, 0, 0);
    issue(OP_CLEAR, 0, 0, 0, 0, CELL_OCCUPIED, 0, 0, 7);
    issue(OP_READ, 0, 0, 0, 0, CELL_OCCUPIED, 0, 0, 0);
    issue(OP_READ, 0, 0, 0, 0, CELL_OCCUPIED, 255, 0, 0);

    // random part across grid sizes: tiny, empty, oversized and full
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin cols = 1;   rows = 1;   end
        1: begin cols = 0;   rows = 9;   end
        2: begin cols = 100; rows = 0;   end
        3: begin cols = 511; rows = 300; end
        4: begin cols = 256; rows = 256; end
        5: begin cols = 256; rows = 1;   end
        6: begin cols = 1;   rows = 256; end
        7: begin cols = $urandom_range(0, 511); rows = $urandom_range(0, 511); end
        default: begin cols = $urandom_range(1, 256); rows = $urandom_range(1, 256); end
      endcase
      set_grid(cols, rows);
      repeat (PER_PHASE) random_command();
    end

    drain();
    repeat (20) @(negedge clk);
    $display("covered %0d traces, %0d reads, %0d clears and %0d unused-op commands",
             n_trace, n_read, n_clear, n_spare);
    $display("over %0d grid sizes; %0d results compared, %0d field errors",
             n_sizes, compared, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("grid_ray_tracer: match");
    end else begin
      $display("grid_ray_tracer: mismatch");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/grt_pkg.sv
rtl/grid_ray_tracer.sv
bench/grid_occupancy_checker.sv
bench/tb_grid_ray_tracer.sv
